@@ hdl/rtu_pkg.sv @@
package rtu_pkg;

    localparam int FRAME_BYTES_DEF = 64;

    localparam logic [7:0]  SLAVE_ID_RST  = 8'd1;
    localparam logic [9:0]  GAP_TICKS_RST = 10'd50;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // register indexes of the configuration port
    localparam logic CFG_SLAVE_ID  = 1'b0;
    localparam logic CFG_GAP_TICKS = 1'b1;

    // result status codes
    localparam logic [1:0] STATUS_PAYLOAD = 2'd0;
    localparam logic [1:0] STATUS_CRC_ERR = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK_RD,
        ST_WALK_DATA
    } t_state;

    // receive-side status handed to the frame sequencer
    typedef struct packed {
        logic       receiving;
        logic       overflowed;
        logic       gap_hit;
        logic       room;
        logic       crc_ok;
        logic [7:0] addr_byte;
        logic [7:0] func_byte;
    } t_rx_stat;

    function automatic logic [15:0] crc16_byte(input logic [15:0] c_in, input logic [7:0] d);
        logic [15:0] c;
        c = c_in ^ {8'h00, d};
        for (int b = 0; b < 8; b++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

@@ hdl/rtu_in_if.sv @@
interface rtu_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] rx_byte;

    modport source (output valid, output op, output rx_byte, input ready);
    modport sink   (input valid, input op, input rx_byte, output ready);
endinterface

@@ hdl/rtu_out_if.sv @@
interface rtu_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [7:0] out_byte;
    logic       last;

    modport source (output valid, output status, output out_byte, output last, input ready);
    modport sink   (input valid, input status, input out_byte, input last, output ready);
endinterface

@@ hdl/rtu_frame_receiver_crc_check.sv @@
// Channel   Direction  Payload                      Request
// i_in      sink       op, rx_byte                  one serial byte or one 1 ms tick
// o_out     source     status, out_byte, last       one result of a finished frame
//
// The CRC is folded in as bytes arrive, so a frame end loads a single result, or
// for a good frame a length byte and then a buffer walk over the stored bytes:
// the buffer walk issues one frame store read per cycle while the output register is free.
// Input is held off during the walk and while an undelivered result blocks the
// output register. Synchronous active-low reset; the frame store is not cleared.
module rtu_frame_receiver_crc_check #(
    parameter int FRAME_BYTES = rtu_pkg::FRAME_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rtu_in_if.sink      i_in,
    rtu_out_if.source   o_out,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [9:0]  i_cfg_data
);

    localparam int AW = $clog2(FRAME_BYTES);
    localparam int CW = $clog2(FRAME_BYTES + 1);

    logic [7:0]        r_slave_id;
    logic [9:0]        r_gap_ticks;

    rtu_pkg::t_state   r_state, n_state;
    logic [AW-1:0]     r_addr, n_addr;
    logic [AW-1:0]     r_end, n_end;
    logic              r_ov, n_ov;
    logic [1:0]        r_status, n_status;
    logic [7:0]        r_byte, n_byte;
    logic              r_last, n_last;

    logic [7:0]        mem [FRAME_BYTES];
    logic [7:0]        r_rdata;
    logic              w_rd;
    logic [AW-1:0]     w_rd_addr;

    logic              w_accept;
    logic              w_byte;
    logic              w_tick;
    logic              w_finish;
    logic              w_load;
    logic              w_slot;
    logic [CW-1:0]     w_count;
    logic [CW-1:0]     w_len;
    rtu_pkg::t_rx_stat w_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slave_id  <= rtu_pkg::SLAVE_ID_RST;
            r_gap_ticks <= rtu_pkg::GAP_TICKS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                rtu_pkg::CFG_SLAVE_ID:  r_slave_id  <= i_cfg_data[7:0];
                rtu_pkg::CFG_GAP_TICKS: r_gap_ticks <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_slot     = !r_ov || o_out.ready;
    assign i_in.ready = (r_state == rtu_pkg::ST_IDLE) && w_slot;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_byte     = w_accept && !i_in.op;
    assign w_tick     = w_accept && i_in.op;
    assign w_finish   = w_tick && w_stat.receiving && w_stat.gap_hit;
    assign w_len      = w_count - CW'(3);

    rtu_rx_track #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_track (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_byte      (w_byte),
        .i_rx_byte   (i_in.rx_byte),
        .i_tick      (w_tick),
        .i_clear     (w_finish),
        .i_gap_ticks (r_gap_ticks),
        .o_count     (w_count),
        .o_stat      (w_stat)
    );

    always_ff @(posedge i_clk) begin
        if (w_byte && w_stat.room) begin
            mem[w_count[AW-1:0]] <= i_in.rx_byte;
        end
        if (w_rd) begin
            r_rdata <= mem[w_rd_addr];
        end
    end

    always_comb begin
        n_state   = r_state;
        n_addr    = r_addr;
        n_end     = r_end;
        n_status  = r_status;
        n_byte    = r_byte;
        n_last    = r_last;
        w_load    = 1'b0;
        w_rd      = 1'b0;
        w_rd_addr = r_addr;

        case (r_state)
            rtu_pkg::ST_IDLE: begin
                // drop frames for another address without a result
                if (w_finish && (w_stat.addr_byte == r_slave_id)) begin
                    w_load = 1'b1;
                    n_byte = w_stat.func_byte;
                    n_last = 1'b1;
                    if (w_stat.overflowed) begin
                        n_status = rtu_pkg::STATUS_OVERFLOW;
                    end else if ((w_count < CW'(3)) || !w_stat.crc_ok) begin
                        n_status = rtu_pkg::STATUS_CRC_ERR;
                    end else begin
                        n_status = rtu_pkg::STATUS_PAYLOAD;
                        n_byte   = 8'(w_len);
                        n_last   = (w_count == CW'(3));
                        n_addr   = AW'(1);
                        n_end    = w_len[AW-1:0];
                        if (w_count != CW'(3)) begin
                            n_state = rtu_pkg::ST_WALK_RD;
                        end
                    end
                end
            end
            rtu_pkg::ST_WALK_RD: begin
                w_rd    = 1'b1;
                n_state = rtu_pkg::ST_WALK_DATA;
            end
            rtu_pkg::ST_WALK_DATA: begin
                if (w_slot) begin
                    w_load   = 1'b1;
                    n_status = rtu_pkg::STATUS_PAYLOAD;
                    n_byte   = r_rdata;
                    n_last   = (r_addr == r_end);
                    if (r_addr == r_end) begin
                        n_state = rtu_pkg::ST_IDLE;
                    end else begin
                        // prefetch the next byte while this one goes out
                        w_rd      = 1'b1;
                        w_rd_addr = r_addr + AW'(1);
                        n_addr    = r_addr + AW'(1);
                    end
                end
            end
            default: begin
                n_state = rtu_pkg::ST_IDLE;
            end
        endcase

        n_ov = w_load || (r_ov && !o_out.ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rtu_pkg::ST_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr   <= n_addr;
        r_end    <= n_end;
        r_status <= n_status;
        r_byte   <= n_byte;
        r_last   <= n_last;
    end

    assign o_out.valid    = r_ov;
    assign o_out.status   = r_status;
    assign o_out.out_byte = r_byte;
    assign o_out.last     = r_last;

`ifndef SYNTHESIS
    a_load_free_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> (!r_ov || o_out.ready))
        else $error("result loaded over an undelivered one");

    a_walk_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rtu_pkg::ST_WALK_DATA) |-> (r_addr <= r_end))
        else $error("buffer walk past frame end");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_count <= CW'(FRAME_BYTES))
        else $error("byte count beyond frame store");

    a_walk_no_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != rtu_pkg::ST_IDLE) |=> !(w_byte && w_stat.room) || (r_state == rtu_pkg::ST_IDLE))
        else $error("frame store written during buffer walk");
`endif

endmodule

@@ hdl/rtu_rx_track.sv @@
module rtu_rx_track #(
    parameter int FRAME_BYTES = rtu_pkg::FRAME_BYTES_DEF,
    localparam int CW = $clog2(FRAME_BYTES + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_byte,
    input  logic [7:0]           i_rx_byte,
    input  logic                 i_tick,
    input  logic                 i_clear,
    input  logic [9:0]           i_gap_ticks,
    output logic [CW-1:0]        o_count,
    output rtu_pkg::t_rx_stat    o_stat
);

    logic          r_receiving;
    logic [CW-1:0] r_count;
    logic [9:0]    r_idle;
    logic          r_ovf;
    logic [15:0]   r_crc;
    logic [7:0]    r_b0;
    logic [7:0]    r_b1;
    logic [7:0]    r_tail0;
    logic [7:0]    r_tail1;
    logic          w_room;

    assign w_room = r_count < CW'(FRAME_BYTES);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_receiving <= 1'b0;
            r_count     <= '0;
            r_idle      <= '0;
            r_ovf       <= 1'b0;
            r_crc       <= rtu_pkg::CRC_INIT;
        end else if (i_byte) begin
            r_receiving <= 1'b1;
            r_idle      <= '0;
            if (w_room) begin
                r_count <= r_count + CW'(1);
                // fold the byte that has just left the two-byte trailer
                if (r_count >= CW'(2)) begin
                    r_crc <= rtu_pkg::crc16_byte(r_crc, r_tail1);
                end
            end else begin
                r_ovf <= 1'b1;
            end
        end else if (i_tick && r_receiving) begin
            r_idle <= r_idle + 10'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte && w_room) begin
            r_tail1 <= r_tail0;
            r_tail0 <= i_rx_byte;
            if (r_count == CW'(0)) begin
                r_b0 <= i_rx_byte;
            end
            if (r_count == CW'(1)) begin
                r_b1 <= i_rx_byte;
            end
        end
    end

    assign o_count            = r_count;
    assign o_stat.receiving   = r_receiving;
    assign o_stat.overflowed  = r_ovf;
    assign o_stat.gap_hit     = r_idle >= i_gap_ticks;
    assign o_stat.room        = w_room;
    assign o_stat.crc_ok      = (r_tail1 == r_crc[7:0]) && (r_tail0 == r_crc[15:8]);
    assign o_stat.addr_byte   = r_b0;
    assign o_stat.func_byte   = (r_count >= CW'(2)) ? r_b1 : 8'h00;

endmodule
